// ===== rtl/dsre_pkg.sv =====
// dsre_pkg: element type, opcode codes and field widths shared by the
// dual stack rotate engine memory and top level. No dependencies.
package dsre_pkg;

	localparam int VAL_W  = 32;
	localparam int RANK_W = 16;
	localparam int SIZE_W = 9;

	typedef struct packed {
		logic signed [VAL_W-1:0] value;
		logic [RANK_W-1:0]       rank;
	} elem_t;

	typedef enum logic [2:0] {
		OP_SWAP = 3'd0,
		OP_PUT  = 3'd1,
		OP_ROT  = 3'd2,
		OP_RROT = 3'd3,
		OP_LOAD = 3'd4
	} op_t;

endpackage

// ===== rtl/dual_stack_rotate_engine_core.sv =====
// dual_stack_rotate_engine_core: two circular-buffer stacks with swap, put,
// rotate, reverse rotate and load. Depends on dsre_pkg and dsre_mem.
//
// usage
//   input channel: in_valid / in_stall with opcode, pile, load_value,
//   load_rank. one beat is taken at an edge with in_valid high and in_stall
//   low. in_stall is high while an operation is in flight.
//   output channel: out_valid / out_stall with done_res, top_value,
//   top_rank, size_a, size_b, one result beat per input beat, held in an
//   output register until taken.
//   timing: the accept cycle issues the memory reads, the next cycle does
//   the write-back and loads the result into the output register; no new
//   beat is taken until that operation is through. swap writes two
//   entries through the single write port, in two write-back steps.
//   the stores have registered read ports, hence the separate read step.
//   a stalled receiver holds the finished beat in the output register; the
//   next operation is still accepted and waits in its write-back step until
//   the output register frees.
//   reset clears bases, counts and all control; the stores are not cleared,
//   only live entries are ever used in a result or a write.
module dual_stack_rotate_engine_core import dsre_pkg::*; #(
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	output logic                     in_stall,
	input  logic [2:0]               opcode,
	input  logic                     pile,
	input  logic signed [VAL_W-1:0]  load_value,
	input  logic [RANK_W-1:0]        load_rank,
	output logic                     out_valid,
	input  logic                     out_stall,
	output logic                     done_res,
	output logic signed [VAL_W-1:0]  top_value,
	output logic [RANK_W-1:0]        top_rank,
	output logic [SIZE_W-1:0]        size_a,
	output logic [SIZE_W-1:0]        size_b
);

	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [CW:0]   DEPTH_X = (CW+1)'(DEPTH);
	localparam logic [CW-1:0] ONE_C   = CW'(1);
	localparam logic [CW-1:0] TWO_C   = CW'(2);
	localparam logic [CW-1:0] FULL_C  = CW'(DEPTH);
	localparam logic [AW-1:0] LAST_P  = AW'(DEPTH - 1);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_EXEC,
		ST_SWAP2
	} state_t;

	function automatic logic [AW-1:0] slot_of(input logic [AW-1:0] b, input logic [CW-1:0] pos);
		logic [CW:0] sum;
		sum = {{(CW+1-AW){1'b0}}, b} + {1'b0, pos};
		if (sum >= DEPTH_X) begin
			sum = sum - DEPTH_X;
		end
		return sum[AW-1:0];
	endfunction

	function automatic logic [SIZE_W-1:0] to_size(input logic [CW-1:0] c);
		logic [CW+SIZE_W-1:0] ext;
		ext = {{SIZE_W{1'b0}}, c};
		return ext[SIZE_W-1:0];
	endfunction

	state_t                   state_q;
	op_t                      op_q;
	logic                     pile_q;
	elem_t                    load_q;
	logic [AW-1:0]            base_q [2];
	logic [CW-1:0]            count_q [2];
	logic                     out_valid_q;
	logic                     done_q;
	elem_t                    top_q;
	logic [SIZE_W-1:0]        size_a_q;
	logic [SIZE_W-1:0]        size_b_q;

	logic                     accept;
	logic                     sp;
	op_t                      op_sel;
	logic [CW-1:0]            cs;
	logic [CW-1:0]            co;
	logic [AW-1:0]            bs;
	logic [AW-1:0]            bo;
	logic [AW-1:0]            top_s;
	logic [AW-1:0]            sec_s;
	logic [AW-1:0]            top_o;
	logic [AW-1:0]            push_s;
	logic [AW-1:0]            prev_b;
	logic [AW-1:0]            next_b;
	logic [AW-1:0]            ra0;
	logic [AW-1:0]            ra1;
	elem_t                    rd0_a;
	elem_t                    rd1_a;
	elem_t                    rd0_b;
	elem_t                    rd1_b;
	elem_t                    d0;
	elem_t                    d1;
	logic                     ok;
	logic                     wr;
	logic [AW-1:0]            wa;
	elem_t                    wd;
	elem_t                    new_top;
	logic [CW-1:0]            new_cs;
	logic [CW-1:0]            new_co;
	logic [AW-1:0]            new_bs;
	logic                     to_swap2;
	logic                     out_free;
	logic                     commit;
	logic                     finish;
	logic                     do_write;
	logic                     we_a;
	logic                     we_b;
	logic [CW-1:0]            new_ca;
	logic [CW-1:0]            new_cb;

	assign accept   = in_valid && (state_q == ST_IDLE);
	assign in_stall = (state_q != ST_IDLE);

	// address generation, shared by the read issue and the write-back
	assign sp     = (state_q == ST_IDLE) ? pile : pile_q;
	assign op_sel = (state_q == ST_IDLE) ? op_t'(opcode) : op_q;
	assign cs     = count_q[sp];
	assign co     = count_q[~sp];
	assign bs     = base_q[sp];
	assign bo     = base_q[~sp];
	assign top_s  = slot_of(bs, cs - ONE_C);
	assign sec_s  = slot_of(bs, cs - TWO_C);
	assign top_o  = slot_of(bo, co - ONE_C);
	assign push_s = slot_of(bs, cs);
	assign prev_b = (bs == '0) ? LAST_P : bs - AW'(1);
	assign next_b = (bs == LAST_P) ? '0 : bs + AW'(1);

	always_comb begin
		case (op_sel)
			OP_PUT:  ra0 = top_o;
			OP_RROT: ra0 = bs;
			default: ra0 = top_s;
		endcase
		ra1 = (op_sel == OP_PUT) ? top_s : sec_s;
	end

	dsre_mem #(.DEPTH(DEPTH)) u_mem_a (
		.clk   (clk),
		.rd_en (accept),
		.ra0   (ra0),
		.ra1   (ra1),
		.we    (we_a),
		.wa    (wa),
		.wd    (wd),
		.rd0   (rd0_a),
		.rd1   (rd1_a)
	);

	dsre_mem #(.DEPTH(DEPTH)) u_mem_b (
		.clk   (clk),
		.rd_en (accept),
		.ra0   (ra0),
		.ra1   (ra1),
		.we    (we_b),
		.wa    (wa),
		.wd    (wd),
		.rd0   (rd0_b),
		.rd1   (rd1_b)
	);

	assign d0 = ((op_q == OP_PUT) ? ~pile_q : pile_q) ? rd0_b : rd0_a;
	assign d1 = pile_q ? rd1_b : rd1_a;

	// modify step
	always_comb begin
		ok       = 1'b0;
		wr       = 1'b0;
		wa       = push_s;
		wd       = d0;
		new_top  = (cs != '0) ? d0 : '0;
		new_cs   = cs;
		new_co   = co;
		new_bs   = bs;
		to_swap2 = 1'b0;
		if (state_q == ST_SWAP2) begin
			ok      = 1'b1;
			wr      = 1'b1;
			wa      = sec_s;
			wd      = d0;
			new_top = d1;
		end else begin
			case (op_q)
				OP_SWAP: begin
					if (cs >= TWO_C) begin
						ok       = 1'b1;
						wr       = 1'b1;
						wa       = top_s;
						wd       = d1;
						to_swap2 = 1'b1;
					end
				end
				OP_PUT: begin
					if (co != '0 && cs < FULL_C) begin
						ok      = 1'b1;
						wr      = 1'b1;
						wa      = push_s;
						wd      = d0;
						new_top = d0;
						new_cs  = cs + ONE_C;
						new_co  = co - ONE_C;
					end else begin
						new_top = (cs != '0) ? d1 : '0;
					end
				end
				OP_ROT: begin
					if (cs >= TWO_C) begin
						ok      = 1'b1;
						wr      = 1'b1;
						wa      = prev_b;
						wd      = d0;
						new_top = d1;
						new_bs  = prev_b;
					end
				end
				OP_RROT: begin
					if (cs >= TWO_C) begin
						ok      = 1'b1;
						wr      = 1'b1;
						wa      = push_s;
						wd      = d0;
						new_top = d0;
						new_bs  = next_b;
					end
				end
				OP_LOAD: begin
					if (cs < FULL_C) begin
						ok      = 1'b1;
						wr      = 1'b1;
						wa      = push_s;
						wd      = load_q;
						new_top = load_q;
						new_cs  = cs + ONE_C;
					end
				end
				default: begin
					ok = 1'b0;
				end
			endcase
		end
	end

	assign out_free = !out_valid_q || !out_stall;
	assign finish   = ((state_q == ST_EXEC) && !to_swap2 && out_free) ||
	                  ((state_q == ST_SWAP2) && out_free);
	assign commit   = finish || ((state_q == ST_EXEC) && to_swap2);
	assign do_write = commit && wr;
	assign we_a     = do_write && !pile_q;
	assign we_b     = do_write && pile_q;
	assign new_ca   = pile_q ? new_co : new_cs;
	assign new_cb   = pile_q ? new_cs : new_co;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			base_q[0]   <= '0;
			base_q[1]   <= '0;
			count_q[0]  <= '0;
			count_q[1]  <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q <= ST_EXEC;
					end
				end
				ST_EXEC: begin
					if (to_swap2) begin
						state_q <= ST_SWAP2;
					end else if (finish) begin
						state_q <= ST_IDLE;
					end
				end
				ST_SWAP2: begin
					if (finish) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
			if (commit && ok) begin
				count_q[pile_q]  <= new_cs;
				count_q[~pile_q] <= new_co;
				base_q[pile_q]   <= new_bs;
			end
			if (finish) begin
				out_valid_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_q         <= op_t'(opcode);
			pile_q       <= pile;
			load_q.value <= load_value;
			load_q.rank  <= load_rank;
		end
		if (finish) begin
			done_q   <= ok;
			top_q    <= new_top;
			size_a_q <= to_size(new_ca);
			size_b_q <= to_size(new_cb);
		end
	end

	assign out_valid = out_valid_q;
	assign done_res  = done_q;
	assign top_value = top_q.value;
	assign top_rank  = top_q.rank;
	assign size_a    = size_a_q;
	assign size_b    = size_b_q;

`ifndef SYNTH
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q[0] <= FULL_C) && (count_q[1] <= FULL_C))
		else $error("stack count above depth");

	a_accept_exec: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (state_q == ST_EXEC))
		else $error("accepted beat did not enter write-back");

	a_total_count: assert property (@(posedge clk) disable iff (!arst_n)
		1'b1 |=> (({1'b0, count_q[0]} + {1'b0, count_q[1]}) ==
		          $past({1'b0, count_q[0]} + {1'b0, count_q[1]})) ||
		         (({1'b0, count_q[0]} + {1'b0, count_q[1]}) ==
		          $past({1'b0, count_q[0]} + {1'b0, count_q[1]}) + (CW+1)'(1)))
		else $error("total element count changed by more than a load");

	a_result_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> ($past(state_q) != ST_IDLE))
		else $error("result loaded without an operation in flight");
`endif

endmodule

// ===== rtl/dsre_mem.sv =====
// dsre_mem: element store of one stack, one write port and two registered
// read ports. Depends on dsre_pkg for elem_t.
module dsre_mem import dsre_pkg::*; #(
	parameter int DEPTH = 256,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic          clk,
	input  logic          rd_en,
	input  logic [AW-1:0] ra0,
	input  logic [AW-1:0] ra1,
	input  logic          we,
	input  logic [AW-1:0] wa,
	input  elem_t         wd,
	output elem_t         rd0,
	output elem_t         rd1
);

	elem_t mem_q [DEPTH];
	elem_t rd0_q;
	elem_t rd1_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[wa] <= wd;
		end
		if (rd_en) begin
			rd0_q <= mem_q[ra0];
			rd1_q <= mem_q[ra1];
		end
	end

	assign rd0 = rd0_q;
	assign rd1 = rd1_q;

endmodule
